// ===== rtl/cma3d_pkg.sv =====
// Shared types and constants of the centered moving average core.
// Used by every module of the block; depends on nothing.
package cma3d_pkg;

    localparam int MAX_HALF_WINDOW = 15;
    localparam int COORD_W         = 32;
    localparam int HW_W            = 4;
    localparam int DEPTH           = 2 * MAX_HALF_WINDOW + 1;
    localparam int IDX_W           = $clog2(DEPTH);
    localparam int CNT_W           = $clog2(DEPTH + 1);
    localparam int SUM_W           = COORD_W + $clog2(DEPTH);
    localparam int TDATA_W         = 3 * COORD_W;

    localparam logic [HW_W-1:0]  HALF_WINDOW_RST = HW_W'(5);
    localparam logic [CNT_W-1:0] SEEN_MAX        = CNT_W'(MAX_HALF_WINDOW + 1);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [SUM_W-1:0]   t_sum;

    // x sits in the lowest bits, as on the stream data bus
    typedef struct packed {
        t_coord z;
        t_coord y;
        t_coord x;
    } t_point;

    function automatic t_sum sx(input t_coord v);
        return {{(SUM_W - COORD_W){v[COORD_W-1]}}, v};
    endfunction

endpackage

// ===== rtl/cma3d_cell.sv =====
// One stage of the point delay line: takes its neighbor's point on shift.
// Depends on cma3d_pkg.
module cma3d_cell (
    input  logic              i_clk,
    input  logic              i_shift,
    input  cma3d_pkg::t_point i_point,
    output cma3d_pkg::t_point o_point
);
    import cma3d_pkg::*;

    t_point r_point;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_point <= i_point;
        end
    end

    assign o_point = r_point;

endmodule

// ===== rtl/cma3d_div.sv =====
// Serial restoring divider: signed sum over a small count, rounded to nearest,
// ties away from zero, one quotient bit per cycle. Depends on cma3d_pkg.
module cma3d_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  cma3d_pkg::t_sum         i_sum,
    input  logic [cma3d_pkg::CNT_W-1:0] i_den,
    output logic                    o_done,
    output cma3d_pkg::t_coord       o_mean
);
    import cma3d_pkg::*;

    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_neg;
    logic                 r_done;

    logic [SUM_W-1:0]     w_mag;
    logic [CNT_W:0]       w_rem_sh;
    logic                 w_fit;
    t_coord               w_q;

    assign w_mag    = i_sum[SUM_W-1] ? (~i_sum + SUM_W'(1)) : i_sum;
    assign w_rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign w_fit    = (w_rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= DIV_CNT_W'(SUM_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_done <= 1'b1;
            end
        end
    end

    // dividend shifts out of the quotient register as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= w_mag + SUM_W'(i_den >> 1);
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_sum[SUM_W-1];
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[SUM_W-2:0], w_fit};
            r_rem <= w_fit ? CNT_W'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[CNT_W-1:0];
        end
    end

    assign w_q    = r_quo[COORD_W-1:0];
    assign o_mean = r_neg ? -w_q : w_q;
    assign o_done = r_done;

endmodule

// ===== rtl/centered_moving_average_3d_core.sv =====
// Centered moving average of 3D points; top level with sequencer, sums and
// output register. Depends on cma3d_pkg, cma3d_cell and cma3d_div.
//
// Usage:
//   s_axis carries one point per word (x, y, z signed Q16.16), tlast on the
//   final point of a sequence. m_axis carries the smoothed points, tlast on
//   the mean of the final point. The cfg channel writes half_window (0..15)
//   and discards any sequence in progress; it is taken only while idle.
//   A mean leaves half_window points after its center arrives; the point
//   flagged last flushes every pending mean.
// Sequence:
//   A point enters the delay line of 31 cells after the oldest point of a
//   full window drops out of the sums. Each mean starts the bit-serial
//   dividers, which take one quotient bit per cycle over the 37-bit sum, and
//   then loads the output register. A flushed mean first drops points from
//   the window around its center. A last point yields up to 16 means.
// Reset: half_window returns to 5, sums and counts clear, no word is pending.
// A stalled receiver holds the finished mean in the output register; the
// sequencer waits there before loading the next one.
module centered_moving_average_3d_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // points: x [31:0], y [63:32], z [95:64]
    input  logic [cma3d_pkg::TDATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tlast,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // means: x [31:0], y [63:32], z [95:64]
    output logic [cma3d_pkg::TDATA_W-1:0]     m_axis_tdata,
    output logic                              m_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cma3d_pkg::HW_W-1:0]        i_cfg_data
);
    import cma3d_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DROP  = 7'b0000010,
        S_INS   = 7'b0000100,
        S_FDROP = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_PUSH  = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    logic [HW_W-1:0]  r_w, n_w;
    t_sum             r_sum_x, n_sum_x;
    t_sum             r_sum_y, n_sum_y;
    t_sum             r_sum_z, n_sum_z;
    logic [CNT_W-1:0] r_piw, n_piw;
    logic [CNT_W-1:0] r_seen, n_seen;
    logic [HW_W-1:0]  r_pend, n_pend;
    logic             r_last, n_last;
    logic             r_emit_last, n_emit_last;
    t_point           r_in;
    t_point           r_m_point;
    logic             r_m_last;
    logic             r_m_valid;

    t_point           w_cell [DEPTH];
    t_point           w_tail;
    logic [IDX_W-1:0] w_tail_idx;
    logic [CNT_W-1:0] w_span;
    logic [CNT_W-1:0] w_seen_inc;
    logic [HW_W-1:0]  w_pend;
    logic [CNT_W-1:0] w_limit;
    logic             w_s_acc;
    logic             w_cfg_acc;
    logic             w_out_free;
    logic             w_shift;
    logic             w_div_start;
    logic [2:0]       w_div_done;
    logic             w_done;
    t_point           w_mean;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign w_cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_shift       = (r_state == S_INS);
    assign w_div_start   = (r_state == S_DIV);
    assign w_done        = &w_div_done;

    // delay line: cell 0 holds the newest point
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                cma3d_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_point (r_in),
                    .o_point (w_cell[gi])
                );
            end else begin : g_body
                cma3d_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_point (w_cell[gi-1]),
                    .o_point (w_cell[gi])
                );
            end
        end
    endgenerate

    assign w_tail_idx = IDX_W'(r_piw - 1'b1);
    assign w_tail     = w_cell[w_tail_idx];
    assign w_span     = {r_w, 1'b1};
    assign w_seen_inc = (r_seen < SEEN_MAX) ? (r_seen + 1'b1) : r_seen;
    assign w_pend     = !r_last ? '0 :
                        (w_seen_inc < CNT_W'(r_w)) ? w_seen_inc[HW_W-1:0] : r_w;
    assign w_limit    = CNT_W'(r_pend) + CNT_W'(r_w);

    always_comb begin
        n_state     = r_state;
        n_w         = r_w;
        n_sum_x     = r_sum_x;
        n_sum_y     = r_sum_y;
        n_sum_z     = r_sum_z;
        n_piw       = r_piw;
        n_seen      = r_seen;
        n_pend      = r_pend;
        n_last      = r_last;
        n_emit_last = r_emit_last;
        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    n_last  = s_axis_tlast;
                    n_state = S_DROP;
                end
            end
            S_DROP: begin
                if (r_piw >= w_span) begin
                    n_sum_x = r_sum_x - sx(w_tail.x);
                    n_sum_y = r_sum_y - sx(w_tail.y);
                    n_sum_z = r_sum_z - sx(w_tail.z);
                    n_piw   = r_piw - 1'b1;
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                n_sum_x = r_sum_x + sx(r_in.x);
                n_sum_y = r_sum_y + sx(r_in.y);
                n_sum_z = r_sum_z + sx(r_in.z);
                n_piw   = r_piw + 1'b1;
                n_seen  = w_seen_inc;
                n_pend  = w_pend;
                if (w_seen_inc > CNT_W'(r_w)) begin
                    n_emit_last = r_last && (w_pend == '0);
                    n_state     = S_DIV;
                end else if (r_last) begin
                    n_state = S_FDROP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FDROP: begin
                // shrink the window around the next flushed center
                if (r_piw > w_limit) begin
                    n_sum_x = r_sum_x - sx(w_tail.x);
                    n_sum_y = r_sum_y - sx(w_tail.y);
                    n_sum_z = r_sum_z - sx(w_tail.z);
                    n_piw   = r_piw - 1'b1;
                end else begin
                    n_emit_last = (r_pend == HW_W'(1));
                    n_pend      = r_pend - 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    if (r_pend != '0) begin
                        n_state = S_FDROP;
                    end else begin
                        if (r_last) begin
                            n_sum_x = '0;
                            n_sum_y = '0;
                            n_sum_z = '0;
                            n_piw   = '0;
                            n_seen  = '0;
                            n_last  = 1'b0;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // a new half window discards the sequence in progress
        if (w_cfg_acc) begin
            n_w     = i_cfg_data;
            n_sum_x = '0;
            n_sum_y = '0;
            n_sum_z = '0;
            n_piw   = '0;
            n_seen  = '0;
            n_pend  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_w         <= HALF_WINDOW_RST;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_z     <= '0;
            r_piw       <= '0;
            r_seen      <= '0;
            r_pend      <= '0;
            r_last      <= 1'b0;
            r_emit_last <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_w         <= n_w;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_sum_z     <= n_sum_z;
            r_piw       <= n_piw;
            r_seen      <= n_seen;
            r_pend      <= n_pend;
            r_last      <= n_last;
            r_emit_last <= n_emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_in <= t_point'(s_axis_tdata);
        end
    end

    cma3d_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (r_sum_x),
        .i_den   (r_piw),
        .o_done  (w_div_done[0]),
        .o_mean  (w_mean.x)
    );

    cma3d_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (r_sum_y),
        .i_den   (r_piw),
        .o_done  (w_div_done[1]),
        .o_mean  (w_mean.y)
    );

    cma3d_div u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (r_sum_z),
        .i_den   (r_piw),
        .o_done  (w_div_done[2]),
        .o_mean  (w_mean.z)
    );

    // output register: hold the word until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == S_PUSH) && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_PUSH) && w_out_free) begin
            r_m_point <= w_mean;
            r_m_last  <= r_emit_last;
        end
    end

    assign m_axis_tdata  = r_m_point;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tvalid = r_m_valid;

    a_piw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_piw <= CNT_W'(DEPTH))
        else $error("window count beyond delay line depth");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_MAX)
        else $error("seen count past saturation");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_pend == '0))
        else $error("idle with flush means pending");

    a_push_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PUSH) && w_out_free) |=> m_axis_tvalid)
        else $error("finished mean not loaded into output register");

    a_wait_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> !w_done)
        else $error("divider reports done right after start");

endmodule
